// ===== src/psad_pkg.sv =====
// Shared types, constants and the disk-membership function of the spike detector.
// No dependencies; every other file of the block but psad_if takes names from here.
`default_nettype none

package psad_pkg;

  // Default geometry limits (top level parameters default to these)
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int MaxRadius = 7;

  // Saturation value of a run count
  localparam logic [7:0] CountMax = 8'hFF;

  // Configuration register contents
  typedef struct packed {
    logic signed [15:0] value_threshold;
    logic [2:0]         radius;
    logic [7:0]         time_threshold;
    logic [6:0]         frame_width;
    logic [6:0]         frame_height;
  } cfg_t;

  // Per-item verdict control: emit a verdict, and whether the full disk is inside the frame
  typedef struct packed {
    logic emit;
    logic full;
  } flags_t;

  // True when window cell (k rows back, j columns back) lies in the disk of radius r
  // centered at (r, r)
  function automatic logic disk_hit(input int r, input int k, input int j);
    int dk;
    int dj;
    dk = k - r;
    dj = j - r;
    return (k <= 2 * r) && (j <= 2 * r) && (dk * dk + dj * dj <= r * r);
  endfunction

endpackage

`default_nettype wire

// ===== src/psad_if.sv =====
// Valid/ready channel interfaces: sample items in, verdict items out.
// Standalone; no package needed.
`default_nettype none

interface psad_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface psad_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] col;
  logic [5:0] row;
  logic       spike;
  modport source (output valid, output col, output row, output spike, input ready);
  modport sink   (input valid, input col, input row, input spike, output ready);
endinterface

`default_nettype wire

// ===== src/psad_cfg.sv =====
// APB-style configuration register file of the spike detector.
// Depends on psad_pkg (cfg_t).
`default_nettype none

module psad_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output psad_pkg::cfg_t cfg_o
);

  typedef enum logic [2:0] {
    RegValueThr    = 3'd0,
    RegRadius      = 3'd1,
    RegTimeThr     = 3'd2,
    RegFrameWidth  = 3'd3,
    RegFrameHeight = 3'd4
  } reg_idx_e;

  reg_idx_e       idx;
  logic           wr_en;
  psad_pkg::cfg_t cfg_q;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.value_threshold <= 16'sd0;
      cfg_q.radius          <= 3'd1;
      cfg_q.time_threshold  <= 8'd1;
      cfg_q.frame_width     <= 7'd64;
      cfg_q.frame_height    <= 7'd64;
    end else if (wr_en) begin
      unique case (idx)
        RegValueThr:    cfg_q.value_threshold <= pwdata[15:0];
        RegRadius:      cfg_q.radius          <= pwdata[2:0];
        RegTimeThr:     cfg_q.time_threshold  <= pwdata[7:0];
        RegFrameWidth:  cfg_q.frame_width     <= pwdata[6:0];
        RegFrameHeight: cfg_q.frame_height    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (idx)
      RegValueThr:    prdata = {16'b0, cfg_q.value_threshold};
      RegRadius:      prdata = {29'b0, cfg_q.radius};
      RegTimeThr:     prdata = {24'b0, cfg_q.time_threshold};
      RegFrameWidth:  prdata = {25'b0, cfg_q.frame_width};
      RegFrameHeight: prdata = {25'b0, cfg_q.frame_height};
      default:        prdata = 32'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/psad_count.sv =====
// Raster position tracking and per-cell run-count update (read-modify-write of the
// count memory). Depends on psad_pkg and psad_in_if.
`default_nettype none

module psad_count #(
  parameter int MAX_WIDTH  = psad_pkg::MaxWidth,
  parameter int MAX_HEIGHT = psad_pkg::MaxHeight,
  parameter int MAX_RADIUS = psad_pkg::MaxRadius,
  localparam int Cw    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int Lines = 2 * MAX_RADIUS + 1,
  localparam int Sw    = (Lines > 1) ? $clog2(Lines) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  psad_in_if.sink          in_i,
  input  psad_pkg::cfg_t   cfg_i,
  input  logic             dn_ready_i,
  output logic             valid_o,
  output logic             qual_o,
  output logic [Cw-1:0]    col_o,
  output logic [Sw-1:0]    slot_o,
  output psad_pkg::flags_t flags_o,
  output logic [5:0]       x_o,
  output logic [5:0]       y_o
);

  localparam int Rhw   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int DimW  = $clog2(MAX_WIDTH + MAX_HEIGHT + 128);

  // Effective geometry
  logic [DimW-1:0] fw_e, fh_e, rad_e, w_eff, h_eff, r_eff, r2_eff;

  assign fw_e   = DimW'(cfg_i.frame_width);
  assign fh_e   = DimW'(cfg_i.frame_height);
  assign rad_e  = DimW'(cfg_i.radius);
  assign w_eff  = (fw_e == '0) ? DimW'(1) :
                  ((fw_e > DimW'(MAX_WIDTH)) ? DimW'(MAX_WIDTH) : fw_e);
  assign h_eff  = (fh_e == '0) ? DimW'(1) :
                  ((fh_e > DimW'(MAX_HEIGHT)) ? DimW'(MAX_HEIGHT) : fh_e);
  assign r_eff  = (rad_e > DimW'(MAX_RADIUS)) ? DimW'(MAX_RADIUS) : rad_e;
  assign r2_eff = r_eff << 1;

  // Position state
  logic [Cw-1:0]  col_q;
  logic [Rhw-1:0] row_q;
  logic [Sw-1:0]  slot_q;

  logic [DimW-1:0] c0, r0, c1, r1;
  logic [Sw-1:0]   s0, s1;

  function automatic logic [Sw-1:0] slot_inc(input logic [Sw-1:0] s);
    return (s == Sw'(Lines - 1)) ? '0 : s + Sw'(1);
  endfunction

  // Position of this item (wrap for shrunk geometry) and of the next one
  always_comb begin
    c0 = DimW'(col_q);
    r0 = DimW'(row_q);
    s0 = slot_q;
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = r0 + DimW'(1);
      s0 = slot_inc(slot_q);
    end
    if (r0 >= h_eff) begin
      r0 = '0;
      s0 = '0;
    end
    c1 = c0 + DimW'(1);
    r1 = r0;
    s1 = s0;
    if (c1 >= w_eff) begin
      c1 = '0;
      r1 = r0 + DimW'(1);
      s1 = slot_inc(s0);
      if (r1 >= h_eff) begin
        r1 = '0;
        s1 = '0;
      end
    end
  end

  // Handshake and clearing pass
  logic          clr_busy_q;
  logic [Aw-1:0] clr_q;
  logic          v1_q;
  logic          acc, wr_s1;

  assign in_i.ready = !clr_busy_q && (!v1_q || dn_ready_i);
  assign acc        = in_i.valid && in_i.ready;
  assign wr_s1      = v1_q && dn_ready_i;

  function automatic logic [Aw-1:0] AW_MUL(input logic [DimW-1:0] r);
    return Aw'(r) * Aw'(MAX_WIDTH);
  endfunction

  // Stage 0 decode
  logic [Aw-1:0]    addr0;
  logic             raised0;
  psad_pkg::flags_t flags0;

  assign addr0        = AW_MUL(r0) + Aw'(c0);
  assign raised0      = $signed(in_i.sample) >= $signed(cfg_i.value_threshold);
  assign flags0.emit  = (c0 >= r_eff) && (r0 >= r_eff);
  assign flags0.full  = (c0 >= r2_eff) && (r0 >= r2_eff);

  // Stage 1 registers
  logic [Aw-1:0]    addr1_q;
  logic             raised1_q;
  logic [Cw-1:0]    col1_q;
  logic [Sw-1:0]    slot1_q;
  psad_pkg::flags_t flags1_q;
  logic [5:0]       x1_q, y1_q;
  logic             byp_q;
  logic [7:0]       bypv_q, rdata_q;
  logic [7:0]       old1, new1;

  assign old1 = byp_q ? bypv_q : rdata_q;
  assign new1 = !raised1_q ? 8'd0 :
                ((old1 == psad_pkg::CountMax) ? old1 : old1 + 8'd1);

  // Count memory: clearing pass, update write, registered read
  logic [7:0] cnt_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      cnt_mem[clr_q] <= 8'd0;
    end else if (wr_s1) begin
      cnt_mem[addr1_q] <= new1;
    end
    if (acc) begin
      rdata_q <= cnt_mem[addr0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
      v1_q       <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      slot_q     <= '0;
    end else begin
      if (clr_busy_q) begin
        if (clr_q == Aw'(Depth - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_q <= clr_q + Aw'(1);
        end
      end
      if (acc) begin
        v1_q   <= 1'b1;
        col_q  <= Cw'(c1);
        row_q  <= Rhw'(r1);
        slot_q <= s1;
      end else if (dn_ready_i) begin
        v1_q <= 1'b0;
      end
    end
  end

  // Stage 1 payload; bypass covers a write to the same cell on the read edge
  always_ff @(posedge clk_i) begin
    if (acc) begin
      addr1_q   <= addr0;
      raised1_q <= raised0;
      col1_q    <= Cw'(c0);
      slot1_q   <= s0;
      flags1_q  <= flags0;
      x1_q      <= 6'(c0 - r_eff);
      y1_q      <= 6'(r0 - r_eff);
      byp_q     <= wr_s1 && (addr1_q == addr0);
      bypv_q    <= new1;
    end
  end

  assign valid_o = v1_q;
  assign qual_o  = new1 >= cfg_i.time_threshold;
  assign col_o   = col1_q;
  assign slot_o  = slot1_q;
  assign flags_o = flags1_q;
  assign x_o     = x1_q;
  assign y_o     = y1_q;

endmodule

`default_nettype wire

// ===== src/psad_window.sv =====
// Qualified-flag line buffers, sliding disk window and spike verdict stages.
// Depends on psad_pkg and psad_out_if.
`default_nettype none

module psad_window #(
  parameter int MAX_WIDTH  = psad_pkg::MaxWidth,
  parameter int MAX_RADIUS = psad_pkg::MaxRadius,
  localparam int Cw    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int Lines = 2 * MAX_RADIUS + 1,
  localparam int Sw    = (Lines > 1) ? $clog2(Lines) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  psad_pkg::cfg_t   cfg_i,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  logic             qual_i,
  input  logic [Cw-1:0]    col_i,
  input  logic [Sw-1:0]    slot_i,
  input  psad_pkg::flags_t flags_i,
  input  logic [5:0]       x_i,
  input  logic [5:0]       y_i,
  psad_out_if.source       out_o
);

  // Stage valids and readiness chain
  logic v2_q, v3_q, v4_q, ov_q;
  logic rdy_out, rdy4, rdy3, mv1, mv2, mv3, mv4;

  assign rdy_out    = !ov_q || out_o.ready;
  assign rdy4       = !v4_q || rdy_out;
  assign rdy3       = !v3_q || rdy4;
  assign up_ready_o = !v2_q || rdy3;
  assign mv1        = up_valid_i && up_ready_o;
  assign mv2        = v2_q && rdy3;
  assign mv3        = v3_q && rdy4;
  assign mv4        = v4_q && rdy_out;

  // Stage 2 payload
  logic             qual2_q;
  logic [Cw-1:0]    col2_q;
  logic [Sw-1:0]    slot2_q;
  psad_pkg::flags_t flags2_q, flags3_q, flags4_q;
  logic [5:0]       x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  wire  [Lines-1:0] ldat;

  // One line buffer per row slot; read at entry to stage 2, written as an item leaves it
  for (genvar g = 0; g < Lines; g++) begin : g_line
    logic lmem [MAX_WIDTH];
    logic rd_q;
    always_ff @(posedge clk_i) begin
      if (mv2 && (slot2_q == Sw'(g))) begin
        lmem[col2_q] <= qual2_q;
      end
      if (mv1) begin
        rd_q <= lmem[col_i];
      end
    end
    assign ldat[g] = rd_q;
  end

  // Column vector: bit k is the flag k rows above the current cell
  logic [Lines-1:0] vec;

  always_comb begin
    int ti;
    vec[0] = qual2_q;
    for (int k = 1; k < Lines; k++) begin
      ti = int'(slot2_q) - k;
      if (ti < 0) begin
        ti = ti + Lines;
      end
      vec[k] = ldat[Sw'(ti)];
    end
  end

  // Window columns, newest first; shifts as an item enters stage 3
  logic [Lines-1:0] win_q [Lines];

  always_ff @(posedge clk_i) begin
    if (mv2) begin
      win_q[0] <= vec;
      for (int j = 1; j < Lines; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  // Per-row disk check
  int               r_i;
  logic [Lines-1:0] row_ok, rowok4_q;

  assign r_i = (int'(cfg_i.radius) > MAX_RADIUS) ? MAX_RADIUS : int'(cfg_i.radius);

  always_comb begin
    for (int k = 0; k < Lines; k++) begin
      row_ok[k] = 1'b1;
      for (int j = 0; j < Lines; j++) begin
        if (psad_pkg::disk_hit(r_i, k, j) && !win_q[j][k]) begin
          row_ok[k] = 1'b0;
        end
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (mv1) v2_q <= 1'b1;
      else if (rdy3) v2_q <= 1'b0;
      if (mv2) v3_q <= 1'b1;
      else if (rdy4) v3_q <= 1'b0;
      if (mv3) v4_q <= 1'b1;
      else if (rdy_out) v4_q <= 1'b0;
      if (mv4) ov_q <= flags4_q.emit;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (mv1) begin
      qual2_q  <= qual_i;
      col2_q   <= col_i;
      slot2_q  <= slot_i;
      flags2_q <= flags_i;
      x2_q     <= x_i;
      y2_q     <= y_i;
    end
    if (mv2) begin
      flags3_q <= flags2_q;
      x3_q     <= x2_q;
      y3_q     <= y2_q;
    end
    if (mv3) begin
      rowok4_q <= row_ok;
      flags4_q <= flags3_q;
      x4_q     <= x3_q;
      y4_q     <= y3_q;
    end
    if (mv4) begin
      out_o.col   <= x4_q;
      out_o.row   <= y4_q;
      out_o.spike <= flags4_q.full && (&rowok4_q);
    end
  end

  assign out_o.valid = ov_q;

endmodule

`default_nettype wire

// ===== src/persistent_spike_area_detector.sv =====
// Persistent area spike detector: takes one grid sample per cycle in raster order, one
// item per clock, unless clearing or held by output back-pressure, and gives, per sample
// at or past (radius, radius), the verdict for the cell radius up and left; a verdict
// passes stage registers 1 to 4 and the output register. A clearing pass after reset
// zeroes all MAX_WIDTH*MAX_HEIGHT (4096 by default) run-count entries, one per cycle; no
// item is taken meanwhile, configuration writes are. Depends on psad_pkg, psad_if.
`default_nettype none

module persistent_spike_area_detector #(
  parameter int MAX_WIDTH  = psad_pkg::MaxWidth,
  parameter int MAX_HEIGHT = psad_pkg::MaxHeight,
  parameter int MAX_RADIUS = psad_pkg::MaxRadius
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psad_in_if.sink     in_i,
  psad_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int Cw    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Lines = 2 * MAX_RADIUS + 1;
  localparam int Sw    = (Lines > 1) ? $clog2(Lines) : 1;

  psad_pkg::cfg_t   cfg;
  logic             c_valid, c_ready, c_qual;
  logic [Cw-1:0]    c_col;
  logic [Sw-1:0]    c_slot;
  psad_pkg::flags_t c_flags;
  logic [5:0]       c_x, c_y;

  // Register file
  psad_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  // Position and run-count stages
  psad_count #(
    .MAX_WIDTH (MAX_WIDTH), .MAX_HEIGHT (MAX_HEIGHT), .MAX_RADIUS (MAX_RADIUS)
  ) u_count (
    .clk_i, .rst_ni, .in_i,
    .cfg_i      (cfg),
    .dn_ready_i (c_ready),
    .valid_o    (c_valid),
    .qual_o     (c_qual),
    .col_o      (c_col),
    .slot_o     (c_slot),
    .flags_o    (c_flags),
    .x_o        (c_x),
    .y_o        (c_y)
  );

  // Line buffers, window and verdict stages
  psad_window #(
    .MAX_WIDTH (MAX_WIDTH), .MAX_RADIUS (MAX_RADIUS)
  ) u_window (
    .clk_i, .rst_ni,
    .cfg_i      (cfg),
    .up_valid_i (c_valid),
    .up_ready_o (c_ready),
    .qual_i     (c_qual),
    .col_i      (c_col),
    .slot_i     (c_slot),
    .flags_i    (c_flags),
    .x_i        (c_x),
    .y_i        (c_y),
    .out_o
  );

endmodule

`default_nettype wire
